// ===== sv/wcs_pkg.sv =====
// Shared types, field widths and codes for the weighted cell sampler.
package wcs_pkg;

   // Field widths
   localparam int OP_W     = 2;
   localparam int IDX_W    = 12;
   localparam int WEIGHT_W = 32;
   localparam int DELTA_W  = 49;
   localparam int FRAC_W   = 32;
   localparam int VAL_W    = 48;
   localparam int CELLS_W  = 13;
   localparam int PROD_W   = 64;

   // Stream packing
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 64;

   localparam logic [CELLS_W-1:0] CELLS_RESET = 13'd4096;
   localparam logic [VAL_W-1:0]   VAL_MAX     = {VAL_W{1'b1}};

   // Operation codes carried in req_tuser
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_ADJUST = 2'd2;

   typedef enum logic {
      ALU_SAT_ADD,
      ALU_MAC
   } alu_op_type;

   typedef struct packed {
      alu_op_type                 op;
      logic [VAL_W-1:0]           opa;
      logic signed [DELTA_W-1:0]  opb;
      logic [VAL_W-1:0]           opc;
   } alu_req_type;

   typedef struct packed {
      logic [PROD_W-1:0] result;
      logic              less;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_ADJ_RUN,
      ST_ADJ_TOTAL,
      ST_DONE
   } state_type;

endpackage

// ===== sv/wcs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module wcs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wcs_alu.sv =====
// Shared arithmetic unit: saturating signed add, 32x32 multiply-accumulate, compare.
module wcs_alu (
   input  wcs_pkg::alu_req_type req,
   output wcs_pkg::alu_rsp_type rsp
);
   import wcs_pkg::*;

   logic signed [VAL_W+1:0] sum;
   logic [PROD_W-1:0]       product;
   logic [VAL_W-1:0]        sat_sum;

   // Add unsigned base and signed delta, clamp at zero and at full scale
   always_comb begin
      sum = $signed({2'b00, req.opa}) + $signed({req.opb[DELTA_W-1], req.opb});
      if (sum[VAL_W+1]) begin
         sat_sum = '0;
      end else if (sum[VAL_W]) begin
         sat_sum = VAL_MAX;
      end else begin
         sat_sum = sum[VAL_W-1:0];
      end
   end

   // One 32x32 multiplier with an addend
   assign product = req.opa[31:0] * req.opb[31:0];

   always_comb begin
      case (req.op)
         ALU_MAC: rsp.result = product + PROD_W'(req.opc);
         default: rsp.result = PROD_W'(sat_sum);
      endcase
      rsp.less = (req.opa < req.opc);
   end

endmodule

// ===== sv/weighted_cell_sampler.sv =====
// Top level: weighted cell sampler sequencer over a cumulative weight table.
//
// Requests enter on req_* (tuser = operation, tdata = fields) and one response
// per request leaves on rsp_*. The csr_* channel writes cells_in_use and is
// always ready; write it only while no request is in flight.
// A load writes one table entry as running total plus weight (index 0 restarts
// the total). A sample scales the total by a 0.32 fraction and binary-searches
// the table. An adjust adds a signed delta to entries index..cells_in_use-1
// and to the total, clamped to the 48-bit range.
// Steps per request, from acceptance to response valid:
//   load   one saturating add and one table write
//   sample two multiply-accumulate steps, then a binary search with one
//          read per step on the table RAM
//   adjust one read-modify-write per entry, then the total update
// After the response is loaded the block returns to idle for the next request.
// A response waits in its output register while rsp_tready is low; the block
// holds in its final state until that register frees up.
// Reset clears the total to zero and cells_in_use to 4096; table contents are
// undefined until loaded and there is no clearing pass.
module weighted_cell_sampler #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: cell_index[11:0], weight[43:12], delta[92:44], random_fraction[124:93]
   input  logic [wcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: operation[1:0]
   input  logic [wcs_pkg::OP_W-1:0]          req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: chosen_cell[11:0], running_total[59:12]
   output logic [wcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wcs_pkg::CELLS_W-1:0]       csr_data
);
   import wcs_pkg::*;

   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CMPW = (AW + 1 > CELLS_W) ? AW + 1 : CELLS_W;

   // Request fields
   logic [IDX_W-1:0]          req_index;
   logic [WEIGHT_W-1:0]       req_weight;
   logic signed [DELTA_W-1:0] req_delta;
   logic [FRAC_W-1:0]         req_frac;

   assign req_index  = req_tdata[IDX_W-1:0];
   assign req_weight = req_tdata[IDX_W +: WEIGHT_W];
   assign req_delta  = $signed(req_tdata[IDX_W+WEIGHT_W +: DELTA_W]);
   assign req_frac   = req_tdata[IDX_W+WEIGHT_W+DELTA_W +: FRAC_W];

   // Control state
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       total_ff, total_in;
   logic [CELLS_W-1:0]     cells_ff, cells_in;

   // Working registers
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [WEIGHT_W-1:0]       weight_ff, weight_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [IDX_W-1:0]          chosen_ff, chosen_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [VAL_W-1:0]          target_ff, target_in;
   logic [AW-1:0]             lo_ff, lo_in;
   logic [AW-1:0]             up_ff, up_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [IDX_W-1:0]          rsp_cell_ff, rsp_cell_in;
   logic [VAL_W-1:0]          rsp_total_ff, rsp_total_in;

   // RAM and ALU hookup
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [VAL_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [VAL_W-1:0]  ram_rd_data;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   logic [CMPW-1:0]   wide_cells;
   logic [AW-1:0]     last_idx;
   logic [AW:0]       mid_sum;
   logic [AW-1:0]     mid;

   wcs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wcs_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Last active index: zero acts as one cell, clamp to table depth
   always_comb begin
      wide_cells = CMPW'(cells_ff);
      if (cells_ff == '0) begin
         last_idx = '0;
      end else if (wide_cells > CMPW'(TABLE_DEPTH)) begin
         last_idx = AW'(TABLE_DEPTH - 1);
      end else begin
         last_idx = AW'(wide_cells - CMPW'(1));
      end
   end

   // Binary search midpoint
   assign mid_sum = {1'b0, lo_ff} + {1'b0, up_ff};
   assign mid     = mid_sum[AW:1];

   // Sequencer: next state, datapath control and register updates
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      total_in     = total_ff;
      cells_in     = cells_ff;
      idx_in       = idx_ff;
      weight_in    = weight_ff;
      delta_in     = delta_ff;
      frac_in      = frac_ff;
      chosen_in    = chosen_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      ptr_in       = ptr_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_total_in = rsp_total_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff;

      alu_req.op  = ALU_SAT_ADD;
      alu_req.opa = '0;
      alu_req.opb = '0;
      alu_req.opc = '0;

      ram_wr_data = alu_rsp.result[VAL_W-1:0];
      req_tready  = (state_ff == ST_IDLE);

      // take configuration writes at any time
      if (csr_valid) begin
         cells_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in    = req_index;
               weight_in = req_weight;
               delta_in  = req_delta;
               frac_in   = req_frac;
               chosen_in = req_index;
               case (req_tuser)
                  OP_LOAD:   state_in = ST_LOAD;
                  OP_SAMPLE: state_in = ST_MUL_LO;
                  OP_ADJUST: begin
                     if (CMPW'(req_index) <= CMPW'(last_idx)) begin
                        // prefetch the first entry of the suffix
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_index);
                        ptr_in      = AW'(req_index);
                        state_in    = ST_ADJ_RUN;
                     end else begin
                        state_in = ST_ADJ_TOTAL;
                     end
                  end
                  default:   state_in = ST_DONE;
               endcase
            end
         end

         ST_LOAD: begin
            alu_req.op  = ALU_SAT_ADD;
            alu_req.opa = (idx_ff == '0) ? '0 : total_ff;
            alu_req.opb = $signed({{(DELTA_W-WEIGHT_W){1'b0}}, weight_ff});
            if (CMPW'(idx_ff) < CMPW'(TABLE_DEPTH)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(idx_ff);
               total_in    = alu_rsp.result[VAL_W-1:0];
            end
            state_in = ST_DONE;
         end

         ST_MUL_LO: begin
            // low 32 bits of the total times the fraction
            alu_req.op  = ALU_MAC;
            alu_req.opa = VAL_W'(total_ff[31:0]);
            alu_req.opb = $signed({{(DELTA_W-FRAC_W){1'b0}}, frac_ff});
            alu_req.opc = '0;
            prod_in     = alu_rsp.result;
            lo_in       = '0;
            up_in       = last_idx;
            state_in    = ST_MUL_HI;
         end

         ST_MUL_HI: begin
            // high 16 bits times the fraction plus the carried upper half
            alu_req.op  = ALU_MAC;
            alu_req.opa = VAL_W'(total_ff[VAL_W-1:32]);
            alu_req.opb = $signed({{(DELTA_W-FRAC_W){1'b0}}, frac_ff});
            alu_req.opc = VAL_W'(prod_ff[PROD_W-1:32]);
            target_in   = alu_rsp.result[VAL_W-1:0];
            state_in    = ST_SRCH_RD;
         end

         ST_SRCH_RD: begin
            if (lo_ff < up_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid;
               mid_in      = mid;
               state_in    = ST_SRCH_CMP;
            end else begin
               chosen_in = IDX_W'(lo_ff);
               state_in  = ST_DONE;
            end
         end

         ST_SRCH_CMP: begin
            // narrow the window on target < entry
            alu_req.opa = target_ff;
            alu_req.opc = ram_rd_data;
            if (alu_rsp.less) begin
               up_in = mid_ff;
            end else begin
               lo_in = mid_ff + AW'(1);
            end
            state_in = ST_SRCH_RD;
         end

         ST_ADJ_RUN: begin
            // write back this entry while reading the next
            alu_req.op  = ALU_SAT_ADD;
            alu_req.opa = ram_rd_data;
            alu_req.opb = delta_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            if (ptr_ff < last_idx) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + AW'(1);
               ptr_in      = ptr_ff + AW'(1);
            end else begin
               state_in = ST_ADJ_TOTAL;
            end
         end

         ST_ADJ_TOTAL: begin
            alu_req.op  = ALU_SAT_ADD;
            alu_req.opa = total_ff;
            alu_req.opb = delta_ff;
            total_in    = alu_rsp.result[VAL_W-1:0];
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = chosen_ff;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         cells_ff     <= CELLS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         cells_ff     <= cells_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      weight_ff    <= weight_in;
      delta_ff     <= delta_in;
      frac_ff      <= frac_in;
      chosen_ff    <= chosen_in;
      prod_ff      <= prod_in;
      target_ff    <= target_in;
      lo_ff        <= lo_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      ptr_ff       <= ptr_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-VAL_W){1'b0}}, rsp_total_ff, rsp_cell_ff};

`ifndef SYNTHESIS
   // Search window never inverts
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_RD) |-> (lo_ff <= up_ff))
      else $error("search window inverted");

   // Table is written only by a load or an adjust pass
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_LOAD || state_ff == ST_ADJ_RUN))
      else $error("table write outside load or adjust");

   // Adjust pass stays within the active cells
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADJ_RUN) |-> (ram_wr_addr <= last_idx))
      else $error("adjust beyond last active cell");

   // Total moves only in load and adjust-total steps
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD && state_ff != ST_ADJ_TOTAL) |=> $stable(total_ff))
      else $error("total changed outside load or adjust");

   // One request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");
`endif

endmodule
